// ===== hw/rtl/kms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kms_pkg;

    // Default matrix geometry.
    localparam int COLUMNS_DEF = 6;
    localparam int ROWS_DEF    = 9;

    // Fixed field widths of the request and result items.
    localparam int ROW_W    = 9;
    localparam int DRIVE_W  = 6;
    localparam int MAP_W    = 54;
    localparam int STRIDE   = 9;
    localparam int TICK_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE   = 2'd1;

    // Configuration reset values.
    localparam logic [TICK_W-1:0] SETTLE_RST = 8'd1;
    localparam logic [TICK_W-1:0] IDLE_RST   = 8'd10;
    localparam logic [TICK_W-1:0] TICK_MAX   = 8'hFF;

    // Request actions.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic             action;
        logic [ROW_W-1:0] row_levels;
    } t_in;

    typedef struct packed {
        logic [DRIVE_W-1:0] column_drive;
        logic               snapshot_valid;
        logic [MAP_W-1:0]   held_keys;
        logic [MAP_W-1:0]   pressed_keys;
        logic [MAP_W-1:0]   released_keys;
    } t_out;

endpackage

`default_nettype wire

// ===== hw/rtl/keypad_matrix_scanner.sv =====
// Key matrix scanner.
// The input channel (i_in_valid / o_in_stall, payload i_in_data) carries one
// request per cycle unless stalled: a tick with the sampled row levels, or a
// read. Each tick advances the settle or idle counter; when the settle count is
// reached the addressed column is sampled into its held, pressed and released
// maps and the scan moves to the next column. After the last column the scan
// pauses for the idle count. A read returns all three maps, clears them and
// keeps the held map as the reference for the next pressed/released marks.
// Every request gives exactly one result on o_out_valid / i_out_stall.
// The result register loads on the edge that accepts the request. Throughput
// is one request per cycle; the single result register sets this, and while
// it holds a stalled result the input is stalled too, so nothing is lost or
// repeated.
// Configuration writes (i_cfg_valid / o_cfg_ready) are taken every cycle.
// Synchronous active-low reset restores the register defaults (settle 1,
// idle 10), column zero, and clears all maps and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module keypad_matrix_scanner #(
    parameter int COLUMNS = kms_pkg::COLUMNS_DEF,
    parameter int ROWS    = kms_pkg::ROWS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire  kms_pkg::t_in                i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output kms_pkg::t_out                     o_out_data,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [kms_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [kms_pkg::TICK_W-1:0]        i_cfg_data
);
    import kms_pkg::*;

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    logic [TICK_W-1:0] r_settle, r_idle_ticks;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_idle, n_idle;
    logic [TICK_W-1:0] r_tick, n_tick, tick_inc;
    logic [ROWS-1:0]   r_held [COLUMNS];
    logic [ROWS-1:0]   r_press [COLUMNS];
    logic [ROWS-1:0]   r_rel [COLUMNS];
    logic [ROWS-1:0]   r_prev [COLUMNS];
    logic              r_out_valid;
    t_out              r_out, n_out;
    logic              in_acc, do_sample, is_read;
    logic [ROWS-1:0]   sample_rows;
    logic [COL_W-1:0]  drive_col;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign is_read     = (i_in_data.action == ACT_READ);
    assign sample_rows = ~i_in_data.row_levels[ROWS-1:0];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle     <= SETTLE_RST;
            r_idle_ticks <= IDLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SETTLE: r_settle     <= i_cfg_data;
                CFG_IDLE:   r_idle_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Tick counting, column sequencing and the next drive pattern.
    always_comb begin
        tick_inc  = (r_tick != TICK_MAX) ? r_tick + 1'b1 : r_tick;
        n_tick    = r_tick;
        n_col     = r_col;
        n_idle    = r_idle;
        do_sample = 1'b0;
        if (!is_read) begin
            n_tick = tick_inc;
            if (r_idle) begin
                if (tick_inc >= r_idle_ticks) begin
                    n_idle = 1'b0;
                    n_tick = '0;
                end
            end else if (tick_inc >= r_settle) begin
                do_sample = 1'b1;
                n_tick    = '0;
                if (r_col >= LAST_COL) begin
                    n_col  = '0;
                    n_idle = (r_idle_ticks != '0);
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
        drive_col = n_idle ? LAST_COL : n_col;
    end

    // Result item: drive pattern always, maps only for a read.
    always_comb begin
        n_out                = '0;
        n_out.snapshot_valid = is_read;
        for (int i = 0; i < DRIVE_W; i++) begin
            n_out.column_drive[i] = (int'(drive_col) != i);
        end
        if (is_read) begin
            for (int c = 0; c < COLUMNS; c++) begin
                if ((c + 1) * STRIDE <= MAP_W) begin
                    n_out.held_keys[c*STRIDE +: ROWS]     = r_held[c];
                    n_out.pressed_keys[c*STRIDE +: ROWS]  = r_press[c];
                    n_out.released_keys[c*STRIDE +: ROWS] = r_rel[c];
                end
            end
        end
    end

    // Scan state and the per-column maps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_idle <= 1'b0;
            r_tick <= '0;
            for (int c = 0; c < COLUMNS; c++) begin
                r_held[c]  <= '0;
                r_press[c] <= '0;
                r_rel[c]   <= '0;
                r_prev[c]  <= '0;
            end
        end else if (in_acc) begin
            r_col  <= n_col;
            r_idle <= n_idle;
            r_tick <= n_tick;
            for (int c = 0; c < COLUMNS; c++) begin
                if (is_read) begin
                    r_prev[c]  <= r_held[c];
                    r_held[c]  <= '0;
                    r_press[c] <= '0;
                    r_rel[c]   <= '0;
                end else if (do_sample && (r_col == COL_W'(c))) begin
                    r_held[c]  <= sample_rows;
                    r_press[c] <= r_press[c] | (sample_rows & ~r_prev[c]);
                    r_rel[c]   <= r_rel[c] |
                                  (~sample_rows & (r_prev[c] | r_press[c] |
                                  (sample_rows & ~r_prev[c])));
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    // An accepted request always leaves a result waiting.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted request produced no result");

    // A read answers with a snapshot and clears the first column's maps.
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_read) |=> (r_out.snapshot_valid && r_press[0] == '0 &&
                                 r_rel[0] == '0 && r_held[0] == '0))
        else $error("read did not return a snapshot or clear the maps");

    // A read never moves the scan.
    a_read_holds_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_read) |=> ($stable(r_col) && $stable(r_idle) && $stable(r_tick)))
        else $error("read changed the scan state");

    // The pause only starts after wrapping to column zero.
    a_idle_at_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_idle) |-> (r_col == '0 && r_tick == '0))
        else $error("idle pause entered away from the wrap point");

    // A stalled result stays put.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

import kms_pkg::*;

// Tracks the scanner state, predicts one result per accepted request and
// compares the results that come back in order.
class scan_scoreboard;
    logic [TICK_W-1:0] settle_limit;
    logic [TICK_W-1:0] pause_limit;
    logic [TICK_W-1:0] tick_count;
    logic [2:0]        scan_col;
    logic              in_pause;
    logic [ROW_W-1:0]  held_rows[COLUMNS_DEF];
    logic [ROW_W-1:0]  pressed_rows[COLUMNS_DEF];
    logic [ROW_W-1:0]  released_rows[COLUMNS_DEF];
    logic [ROW_W-1:0]  last_read_rows[COLUMNS_DEF];
    t_out              pending_results[$];
    int                mismatch_count;
    int                reads_seen;
    int                ticks_seen;
    int                results_checked;

    function new();
        settle_limit = SETTLE_RST;
        pause_limit  = IDLE_RST;
        tick_count   = '0;
        scan_col     = '0;
        in_pause     = 1'b0;
        for (int c = 0; c < COLUMNS_DEF; c++) begin
            held_rows[c]      = '0;
            pressed_rows[c]   = '0;
            released_rows[c]  = '0;
            last_read_rows[c] = '0;
        end
        mismatch_count  = 0;
        reads_seen      = 0;
        ticks_seen      = 0;
        results_checked = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] value);
        if (idx == CFG_SETTLE) begin
            settle_limit = value;
        end else if (idx == CFG_IDLE) begin
            pause_limit = value;
        end
    endfunction

    // During the pause the last column stays driven low.
    function logic [DRIVE_W-1:0] drive_levels();
        logic [DRIVE_W-1:0] levels;
        levels = '1;
        levels[in_pause ? COLUMNS_DEF - 1 : int'(scan_col)] = 1'b0;
        return levels;
    endfunction

    // Advance the scanner by one request and queue the result it gives.
    function void note_request(t_in req);
        t_out             expected;
        logic [ROW_W-1:0] closed;
        expected = '0;
        if (req.action == ACT_READ) begin
            reads_seen++;
            expected.column_drive   = drive_levels();
            expected.snapshot_valid = 1'b1;
            for (int c = 0; c < COLUMNS_DEF; c++) begin
                expected.held_keys[c*STRIDE +: ROW_W]     = held_rows[c];
                expected.pressed_keys[c*STRIDE +: ROW_W]  = pressed_rows[c];
                expected.released_keys[c*STRIDE +: ROW_W] = released_rows[c];
                last_read_rows[c] = held_rows[c];
                held_rows[c]      = '0;
                pressed_rows[c]   = '0;
                released_rows[c]  = '0;
            end
        end else begin
            ticks_seen++;
            if (tick_count != TICK_MAX) begin
                tick_count = tick_count + 1'b1;
            end
            if (in_pause) begin
                if (tick_count >= pause_limit) begin
                    in_pause   = 1'b0;
                    tick_count = '0;
                end
            end else if (tick_count >= settle_limit) begin
                // Sample the addressed column; marks are taken against the last read.
                closed = ~req.row_levels;
                held_rows[scan_col]     = closed;
                pressed_rows[scan_col]  = pressed_rows[scan_col] |
                                          (closed & ~last_read_rows[scan_col]);
                released_rows[scan_col] = released_rows[scan_col] |
                    (~closed & (last_read_rows[scan_col] | pressed_rows[scan_col]));
                tick_count = '0;
                if (scan_col == COLUMNS_DEF - 1) begin
                    scan_col = '0;
                    in_pause = (pause_limit != 0);
                end else begin
                    scan_col = scan_col + 1'b1;
                end
            end
            expected.column_drive = drive_levels();
        end
        pending_results.push_back(expected);
    endfunction

    task report_mismatch(string what);
        mismatch_count++;
        $display("mismatch at result %0d: %s", results_checked, what);
    endtask

    task check_result(t_out got);
        t_out want;
        results_checked++;
        if (pending_results.size() == 0) begin
            report_mismatch("result arrived with no request waiting");
            return;
        end
        want = pending_results.pop_front();
        if (got.column_drive !== want.column_drive) begin
            report_mismatch($sformatf("column_drive %h, predicted %h",
                                      got.column_drive, want.column_drive));
        end
        if (got.snapshot_valid !== want.snapshot_valid) begin
            report_mismatch($sformatf("snapshot_valid %b, predicted %b",
                                      got.snapshot_valid, want.snapshot_valid));
        end
        if (got.held_keys !== want.held_keys) begin
            report_mismatch($sformatf("held_keys %h, predicted %h",
                                      got.held_keys, want.held_keys));
        end
        if (got.pressed_keys !== want.pressed_keys) begin
            report_mismatch($sformatf("pressed_keys %h, predicted %h",
                                      got.pressed_keys, want.pressed_keys));
        end
        if (got.released_keys !== want.released_keys) begin
            report_mismatch($sformatf("released_keys %h, predicted %h",
                                      got.released_keys, want.released_keys));
        end
    endtask
endclass

module tb;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 7;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in                  i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SETTLE;
    logic [TICK_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out                 o_out_data;
    logic                 o_cfg_ready;

    scan_scoreboard sb;
    int             cycle_count     = 0;
    int             sender_idle_pct = 0;
    int             stall_pct       = 0;
    int             settings_used   = 1;

    // Per phase: settle, pause, sender idle and receiver stall percentages, requests.
    int phase_settle[PHASES] = '{1, 2, 3, 1, 1, 255, 1};
    int phase_pause[PHASES]  = '{0, 3, 1, 5, 255, 2, 10};
    int phase_idle[PHASES]   = '{0, 80, 0, 32, 0, 32, 0};
    int phase_stall[PHASES]  = '{0, 0, 80, 32, 0, 32, 0};
    int phase_count[PHASES]  = '{130, 130, 130, 130, 100, 280, 50};

    keypad_matrix_scanner u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watch both channels: check results, then note newly accepted requests.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_request(i_in_data);
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", sb.pending_results.size());
            $display("[keypad_matrix_scanner] ERROR");
            $finish;
        end
    end

    // Offer one request, with random idle cycles first, until it is taken.
    task send_request(input t_in req);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop offering requests until every predicted result has come back.
    task pause_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    // Write both registers back to back once the scanner has drained.
    task apply_settings(input logic [TICK_W-1:0] settle, input logic [TICK_W-1:0] pause);
        pause_until_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SETTLE;
        i_cfg_data  <= settle;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(CFG_SETTLE, settle);
        i_cfg_index <= CFG_IDLE;
        i_cfg_data  <= pause;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(CFG_IDLE, pause);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Keys go down and up one at a time, with reads, chords and noisy samples mixed in.
    task run_key_activity(input int count);
        t_in              req;
        logic [ROW_W-1:0] keys_down;
        int               pick;
        keys_down = '0;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                pause_until_drained();
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                req.action     = ACT_READ;
                req.row_levels = ROW_W'($urandom);
            end else begin
                if (pick < 18) begin
                    keys_down[$urandom_range(ROW_W - 1)] ^= 1'b1;
                end else if (pick < 22) begin
                    keys_down = ROW_W'($urandom);
                end
                req.action     = ACT_TICK;
                req.row_levels = (pick >= 94) ? ROW_W'($urandom) : ~keys_down;
            end
            send_request(req);
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty read, one pass over all columns, reads in the pause.
        send_request(t_in'{ACT_READ, 9'h1FF});
        send_request(t_in'{ACT_TICK, 9'h1FF});
        send_request(t_in'{ACT_TICK, 9'h000});
        send_request(t_in'{ACT_TICK, 9'h1FE});
        send_request(t_in'{ACT_TICK, 9'h0FF});
        send_request(t_in'{ACT_TICK, 9'h155});
        send_request(t_in'{ACT_TICK, 9'h0AA});
        send_request(t_in'{ACT_READ, 9'h000});
        send_request(t_in'{ACT_READ, 9'h1FF});
        send_request(t_in'{ACT_TICK, 9'h000});
        send_request(t_in'{ACT_READ, 9'h0AA});

        // Zero settle and zero pause: every tick samples and the scan wraps at once.
        apply_settings(8'd0, 8'd0);
        repeat (6) send_request(t_in'{ACT_TICK, 9'h000});
        send_request(t_in'{ACT_READ, 9'h000});
        send_request(t_in'{ACT_TICK, 9'h1FF});
        send_request(t_in'{ACT_TICK, 9'h0F0});
        send_request(t_in'{ACT_TICK, 9'h1FF});
        send_request(t_in'{ACT_TICK, 9'h1FF});
        send_request(t_in'{ACT_TICK, 9'h000});
        send_request(t_in'{ACT_TICK, 9'h155});
        send_request(t_in'{ACT_TICK, 9'h0AA});
        send_request(t_in'{ACT_READ, 9'h1FF});

        // Random key activity under several settings and flow-control mixes.
        for (int p = 0; p < PHASES; p++) begin
            apply_settings(TICK_W'(phase_settle[p]), TICK_W'(phase_pause[p]));
            sender_idle_pct = phase_idle[p];
            stall_pct       = phase_stall[p];
            run_key_activity(phase_count[p]);
        end

        sender_idle_pct = 0;
        stall_pct       = 0;
        pause_until_drained();
        repeat (4) @(posedge i_clk);

        $display("covered %0d tick and %0d read requests under %0d register settings",
                 sb.ticks_seen, sb.reads_seen, settings_used);
        $display("compared %0d results, %0d field mismatches",
                 sb.results_checked, sb.mismatch_count);
        if (sb.mismatch_count == 0) begin
            $display("[keypad_matrix_scanner] OK");
        end else begin
            $display("[keypad_matrix_scanner] ERROR");
        end
        $finish;
    end
endmodule
